// File: rtl/core/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone track sequencer package
// Beat types, action codes, the half period table and the track ROM used
// by the sequencer, its scoreboard and its testbench.
// ----------------------------------------------------------------------------
package tts_pkg;

   // Track set and tone table limits
   localparam int NUM_TRACKS    = 5;
   localparam int TONE_COUNT    = 128;
   localparam int MAX_TRACK_LEN = 8;
   localparam int HP_ROM_DEPTH  = 128;

   localparam logic [15:0] SILENT_HALF_PERIOD = 16'hfffe;
   localparam logic [7:0]  PAUSE_TONE         = 8'hff;
   localparam logic [2:0]  LAST_ENTRY         = 3'd7;

   // Request kinds
   localparam logic REQ_PLAY = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [1:0] {
      ACT_STARTED  = 2'd0,
      ACT_ARMED    = 2'd1,
      ACT_FINISHED = 2'd2,
      ACT_IGNORED  = 2'd3
   } tts_action_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] track_id;
      logic [7:0] repeat_count;
   } tts_req_type;

   typedef struct packed {
      tts_action_type action;
      logic [7:0]     duration_ticks;
      logic           tone_enable;
      logic [15:0]    tone_half_period;
      logic [2:0]     finished_track;
   } tts_rsp_type;

   typedef struct packed {
      logic [7:0] tone;
      logic [7:0] dur;
   } tts_note_type;

   localparam logic [15:0] HALF_PERIOD_ROM [HP_ROM_DEPTH] = '{
      16'h0010, 16'h0011, 16'h0012, 16'h0013, 16'h0014, 16'h0015, 16'h0016, 16'h0017,
      16'h0018, 16'h0019, 16'h001a, 16'h001b, 16'h001c, 16'h001d, 16'h001e, 16'h001f,
      16'h0020, 16'h0022, 16'h0024, 16'h0026, 16'h0028, 16'h002a, 16'h002c, 16'h002e,
      16'h0030, 16'h0033, 16'h0036, 16'h0039, 16'h003c, 16'h003f, 16'h0042, 16'h0046,
      16'h004a, 16'h004e, 16'h0052, 16'h0057, 16'h005c, 16'h0061, 16'h0067, 16'h006d,
      16'h0073, 16'h007a, 16'h0081, 16'h0089, 16'h0091, 16'h009a, 16'h00a3, 16'h00ad,
      16'h00b7, 16'h00c2, 16'h00ce, 16'h00da, 16'h00e7, 16'h00f5, 16'h0104, 16'h0114,
      16'h0125, 16'h0137, 16'h014a, 16'h015e, 16'h0173, 16'h018a, 16'h01a2, 16'h01bc,
      16'h01d7, 16'h01f4, 16'h0213, 16'h0234, 16'h0257, 16'h027c, 16'h02a3, 16'h02cd,
      16'h02f9, 16'h0328, 16'h035a, 16'h038f, 16'h03c7, 16'h0403, 16'h0443, 16'h0487,
      16'h04cf, 16'h051b, 16'h056c, 16'h05c2, 16'h061e, 16'h067f, 16'h06e6, 16'h0754,
      16'h07c9, 16'h0845, 16'h08c9, 16'h0955, 16'h09ea, 16'h0a88, 16'h0b30, 16'h0be3,
      16'h0ca1, 16'h0d6b, 16'h0e41, 16'h0f25, 16'h1017, 16'h1118, 16'h1229, 16'h134b,
      16'h147f, 16'h15c6, 16'h1722, 16'h1894, 16'h1a1d, 16'h1bbe, 16'h1d79, 16'h1f50,
      16'h2145, 16'h2359, 16'h258e, 16'h27e6, 16'h2a64, 16'h2d0a, 16'h2fda, 16'h32d7,
      16'h3604, 16'h3964, 16'h3cfa, 16'h40c9, 16'h44d5, 16'h4922, 16'h4db4, 16'h528f
   };

   // Read one track entry; anything past the stored notes is an end marker
   function automatic tts_note_type fetch_note(input logic [2:0] track,
                                               input logic [2:0] idx);
      tts_note_type n;
      n = '0;
      if (int'(track) < NUM_TRACKS && int'(idx) < MAX_TRACK_LEN) begin
         unique case ({track, idx})
            6'o00:   n = '{tone: 8'd35,      dur: 8'd5};
            6'o01:   n = '{tone: PAUSE_TONE, dur: 8'd5};
            6'o10:   n = '{tone: 8'd40,      dur: 8'd15};
            6'o11:   n = '{tone: PAUSE_TONE, dur: 8'd5};
            6'o20:   n = '{tone: 8'd50,      dur: 8'd50};
            6'o21:   n = '{tone: PAUSE_TONE, dur: 8'd15};
            6'o30:   n = '{tone: 8'd60,      dur: 8'd3};
            6'o31:   n = '{tone: 8'd50,      dur: 8'd3};
            6'o32:   n = '{tone: 8'd40,      dur: 8'd3};
            6'o33:   n = '{tone: 8'd30,      dur: 8'd3};
            6'o34:   n = '{tone: 8'd20,      dur: 8'd3};
            6'o35:   n = '{tone: PAUSE_TONE, dur: 8'd5};
            6'o40:   n = '{tone: 8'd20,      dur: 8'd3};
            6'o41:   n = '{tone: 8'd30,      dur: 8'd3};
            6'o42:   n = '{tone: 8'd40,      dur: 8'd3};
            6'o43:   n = '{tone: 8'd50,      dur: 8'd3};
            6'o44:   n = '{tone: 8'd60,      dur: 8'd3};
            6'o45:   n = '{tone: PAUSE_TONE, dur: 8'd5};
            default: n = '0;
         endcase
      end
      return n;
   endfunction

   // Map a tone index to its half period; pauses and unknown tones are silent
   function automatic logic [15:0] half_period(input logic [7:0] tone);
      logic [15:0] hp;
      hp = SILENT_HALF_PERIOD;
      if (int'(tone) < TONE_COUNT && int'(tone) < HP_ROM_DEPTH) begin
         hp = HALF_PERIOD_ROM[tone[6:0]];
      end
      return hp;
   endfunction

endpackage

// File: rtl/core/tts_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone track sequencer stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface tts_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/tone_track_sequencer.sv
`timescale 1ns / 1ps
// Result: registered, valid in the cycle after its request beat is taken.
// Throughput: one request beat per cycle while results drain; each is two parallel
// track ROM reads and one half period table read ahead of the result register.
// Reset: synchronous, active high; playback goes idle and the result register
// is emptied. A request is taken whenever the result register is free or drains.
// ----------------------------------------------------------------------------
// Tone track sequencer
// Steps buzzer tracks from a fixed ROM on play requests and timer ticks.
// ----------------------------------------------------------------------------
module tone_track_sequencer (
   input  logic         clock,
   input  logic         reset,
   tts_stream_if.sink   req_chan,
   tts_stream_if.source rsp_chan
);

   logic                 playing_ff,  playing_in;
   logic [2:0]           track_ff,    track_in;
   logic [7:0]           repeats_ff,  repeats_in;
   logic [2:0]           entry_ff,    entry_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tts_pkg::tts_rsp_type rsp_ff,      rsp_in;

   tts_pkg::tts_req_type req;
   tts_pkg::tts_note_type note_cur;
   tts_pkg::tts_note_type note_first;
   tts_pkg::tts_note_type note_sel;
   logic [7:0]           repeats_dec;
   logic [2:0]           entry_sel;
   logic                 accept;

   assign req         = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept      = req_chan.valid && req_chan.ready;

   // Look up the current entry and the track head in parallel
   assign note_cur    = tts_pkg::fetch_note(track_ff, entry_ff);
   assign note_first  = tts_pkg::fetch_note(track_ff, 3'd0);
   assign repeats_dec = repeats_ff - 8'd1;

   // Work out the next state and the result beat
   always_comb begin
      playing_in = playing_ff;
      track_in   = track_ff;
      repeats_in = repeats_ff;
      entry_in   = entry_ff;
      rsp_in     = rsp_ff;
      note_sel   = note_cur;
      entry_sel  = entry_ff;
      if (accept) begin
         rsp_in        = '0;
         rsp_in.action = tts_pkg::ACT_IGNORED;
         priority if (req.req_type == tts_pkg::REQ_PLAY) begin
            track_in   = (int'(req.track_id) < tts_pkg::NUM_TRACKS) ? req.track_id[2:0] : 3'd0;
            repeats_in = req.repeat_count;
            entry_in   = 3'd0;
            playing_in = 1'b1;
            rsp_in.action         = tts_pkg::ACT_STARTED;
            rsp_in.duration_ticks = 8'd1;
         end else if (!playing_ff) begin
            // drop ticks while idle
         end else if (note_cur.dur == 8'd0 &&
                      (repeats_dec == 8'd0 || note_first.dur == 8'd0)) begin
            // last pass done, or a track with no notes drains its repeats
            playing_in = 1'b0;
            repeats_in = 8'd0;
            rsp_in.action         = tts_pkg::ACT_FINISHED;
            rsp_in.finished_track = track_ff;
         end else begin
            if (note_cur.dur == 8'd0) begin
               // restart the track
               repeats_in = repeats_dec;
               note_sel   = note_first;
               entry_sel  = 3'd0;
            end
            entry_in = (entry_sel < tts_pkg::LAST_ENTRY) ? entry_sel + 3'd1 : entry_sel;
            rsp_in.action           = tts_pkg::ACT_ARMED;
            rsp_in.duration_ticks   = note_sel.dur;
            rsp_in.tone_enable      = 1'b1;
            rsp_in.tone_half_period = tts_pkg::half_period(note_sel.tone);
         end
      end
   end

   // Load on accept, drain when taken
   assign rsp_valid_in = accept ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff   <= 1'b0;
         track_ff     <= 3'd0;
         repeats_ff   <= 8'd0;
         entry_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         playing_ff   <= playing_in;
         track_ff     <= track_in;
         repeats_ff   <= repeats_in;
         entry_ff     <= entry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

`ifndef SYNTHESIS
   // A pending finished beat means playback has stopped
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.action == tts_pkg::ACT_FINISHED) |-> !playing_ff)
      else $error("finished beat pending while still playing");

   // Idle ticks leave playback idle
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && req.req_type == tts_pkg::REQ_TICK && !playing_ff) |=> !playing_ff)
      else $error("idle tick started playback");

   // A play request always starts playback with a one-tick arm
   a_play_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req.req_type == tts_pkg::REQ_PLAY) |=>
      (playing_ff && rsp_valid_ff && rsp_ff.action == tts_pkg::ACT_STARTED &&
       rsp_ff.duration_ticks == 8'd1))
      else $error("play request did not start playback");
`endif

endmodule

// File: tb/sv/tts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone track sequencer scoreboard
// Watches the request and result channels, steps its own playback model for
// every request beat taken and compares each result beat with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tts_checker
   import tts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  tts_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  tts_rsp_type rsp_payload,
   output int          pending_count,
   output int          mismatch_count
);

   localparam int REPORT_LIMIT = 10;

   // Half periods in 4 us ticks, one per tone index
   localparam logic [15:0] TONE_PERIODS [128] = '{
      16'h0010, 16'h0011, 16'h0012, 16'h0013, 16'h0014, 16'h0015, 16'h0016, 16'h0017,
      16'h0018, 16'h0019, 16'h001a, 16'h001b, 16'h001c, 16'h001d, 16'h001e, 16'h001f,
      16'h0020, 16'h0022, 16'h0024, 16'h0026, 16'h0028, 16'h002a, 16'h002c, 16'h002e,
      16'h0030, 16'h0033, 16'h0036, 16'h0039, 16'h003c, 16'h003f, 16'h0042, 16'h0046,
      16'h004a, 16'h004e, 16'h0052, 16'h0057, 16'h005c, 16'h0061, 16'h0067, 16'h006d,
      16'h0073, 16'h007a, 16'h0081, 16'h0089, 16'h0091, 16'h009a, 16'h00a3, 16'h00ad,
      16'h00b7, 16'h00c2, 16'h00ce, 16'h00da, 16'h00e7, 16'h00f5, 16'h0104, 16'h0114,
      16'h0125, 16'h0137, 16'h014a, 16'h015e, 16'h0173, 16'h018a, 16'h01a2, 16'h01bc,
      16'h01d7, 16'h01f4, 16'h0213, 16'h0234, 16'h0257, 16'h027c, 16'h02a3, 16'h02cd,
      16'h02f9, 16'h0328, 16'h035a, 16'h038f, 16'h03c7, 16'h0403, 16'h0443, 16'h0487,
      16'h04cf, 16'h051b, 16'h056c, 16'h05c2, 16'h061e, 16'h067f, 16'h06e6, 16'h0754,
      16'h07c9, 16'h0845, 16'h08c9, 16'h0955, 16'h09ea, 16'h0a88, 16'h0b30, 16'h0be3,
      16'h0ca1, 16'h0d6b, 16'h0e41, 16'h0f25, 16'h1017, 16'h1118, 16'h1229, 16'h134b,
      16'h147f, 16'h15c6, 16'h1722, 16'h1894, 16'h1a1d, 16'h1bbe, 16'h1d79, 16'h1f50,
      16'h2145, 16'h2359, 16'h258e, 16'h27e6, 16'h2a64, 16'h2d0a, 16'h2fda, 16'h32d7,
      16'h3604, 16'h3964, 16'h3cfa, 16'h40c9, 16'h44d5, 16'h4922, 16'h4db4, 16'h528f
   };

   // Track contents; a zero duration is the end marker
   localparam logic [7:0] NOTE_TONE [5][8] = '{
      '{8'd35, 8'hff, 8'hff, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
      '{8'd40, 8'hff, 8'hff, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
      '{8'd50, 8'hff, 8'hff, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
      '{8'd60, 8'd50, 8'd40, 8'd30, 8'd20, 8'hff, 8'hff, 8'd0},
      '{8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'hff, 8'hff, 8'd0}
   };
   localparam logic [7:0] NOTE_DUR [5][8] = '{
      '{8'd5,  8'd5,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd15, 8'd5,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd50, 8'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd3,  8'd3,  8'd3, 8'd3, 8'd3, 8'd5, 8'd0, 8'd0},
      '{8'd3,  8'd3,  8'd3, 8'd3, 8'd3, 8'd5, 8'd0, 8'd0}
   };

   // Playback state of the model
   logic       active;
   logic [2:0] track_sel;
   logic [7:0] plays_left;
   logic [2:0] note_idx;

   tts_rsp_type playback_rsp_q[$];
   int          errors;

   // Tone index to half period; pauses and unknown tones are silent
   function automatic logic [15:0] tone_period(input logic [7:0] tone);
      if (int'(tone) < TONE_COUNT) begin
         return TONE_PERIODS[tone[6:0]];
      end
      return SILENT_HALF_PERIOD;
   endfunction

   // Duration of one entry; anything outside the stored tracks ends the track
   function automatic logic [7:0] note_dur(input logic [2:0] trk, input logic [2:0] idx);
      if (int'(trk) < NUM_TRACKS && int'(idx) < MAX_TRACK_LEN) begin
         return NOTE_DUR[trk][idx];
      end
      return 8'd0;
   endfunction

   function automatic logic [7:0] note_tone(input logic [2:0] trk, input logic [2:0] idx);
      if (int'(trk) < NUM_TRACKS && int'(idx) < MAX_TRACK_LEN) begin
         return NOTE_TONE[trk][idx];
      end
      return 8'd0;
   endfunction

   // Step the playback model by one request beat and return its result
   function automatic tts_rsp_type advance_playback(input tts_req_type beat);
      tts_rsp_type r;
      logic [7:0]  dur;
      r        = '0;
      r.action = ACT_IGNORED;

      // Play request: load the track and start with one silent tick
      if (beat.req_type == REQ_PLAY) begin
         track_sel        = (int'(beat.track_id) >= NUM_TRACKS) ? 3'd0 : beat.track_id[2:0];
         plays_left       = beat.repeat_count;
         note_idx         = 3'd0;
         active           = 1'b1;
         r.action         = ACT_STARTED;
         r.duration_ticks = 8'd1;
         return r;
      end

      // Tick with nothing playing: drop it
      if (!active) begin
         return r;
      end

      // End marker: count one play, restart or stop; a zero count wraps
      dur = note_dur(track_sel, note_idx);
      while (dur == 8'd0) begin
         plays_left = plays_left - 8'd1;
         if (plays_left == 8'd0) begin
            active           = 1'b0;
            r.action         = ACT_FINISHED;
            r.finished_track = track_sel;
            return r;
         end
         note_idx = 3'd0;
         dur      = note_dur(track_sel, note_idx);
      end

      r.action           = ACT_ARMED;
      r.duration_ticks   = dur;
      r.tone_enable      = 1'b1;
      r.tone_half_period = tone_period(note_tone(track_sel, note_idx));
      if (note_idx < LAST_ENTRY) begin
         note_idx = note_idx + 3'd1;
      end
      return r;
   endfunction

   function automatic void report_rsp(input tts_rsp_type want, input tts_rsp_type got,
                                      input logic orphan);
      errors++;
      if (errors <= REPORT_LIMIT) begin
         if (orphan) begin
            $display("%0t: unexpected result beat: act=%0d dur=%0d en=%0b hp=%h fin=%0d",
                     $realtime, got.action, got.duration_ticks, got.tone_enable,
                     got.tone_half_period, got.finished_track);
         end else begin
            $display("%0t: result mismatch: want act=%0d dur=%0d en=%0b hp=%h fin=%0d",
                     $realtime, want.action, want.duration_ticks, want.tone_enable,
                     want.tone_half_period, want.finished_track);
            $display("%0t:                   got  act=%0d dur=%0d en=%0b hp=%h fin=%0d",
                     $realtime, got.action, got.duration_ticks, got.tone_enable,
                     got.tone_half_period, got.finished_track);
         end
      end
   endfunction

   // Compare the result beat first, then queue the prediction for a new request
   always @(posedge clock) begin
      tts_rsp_type want;
      if (reset) begin
         active     = 1'b0;
         track_sel  = 3'd0;
         plays_left = 8'd0;
         note_idx   = 3'd0;
         errors     = 0;
         playback_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (playback_rsp_q.size() == 0) begin
               report_rsp('0, rsp_payload, 1'b1);
            end else begin
               want = playback_rsp_q.pop_front();
               if (want.action != rsp_payload.action
                   || want.duration_ticks != rsp_payload.duration_ticks
                   || want.tone_enable != rsp_payload.tone_enable
                   || want.tone_half_period != rsp_payload.tone_half_period
                   || want.finished_track != rsp_payload.finished_track) begin
                  report_rsp(want, rsp_payload, 1'b0);
               end
            end
         end
         if (req_valid && req_ready) begin
            playback_rsp_q.push_back(advance_playback(req_payload));
         end
      end
      pending_count  <= playback_rsp_q.size();
      mismatch_count <= errors;
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone track sequencer testbench
// Drives play requests and timer ticks in bursts against a stalling result
// sink: a directed pass over the track set and the special cases, then random
// play sequences with noise. The scoreboard does the checking.
// ----------------------------------------------------------------------------
module tb_top;
   import tts_pkg::*;

   localparam int ITEM_TOTAL    = 1100;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TICK_CAP      = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int pending;
   int mismatches;
   int cycle_count = 0;
   int beats_sent  = 0;
   int burst_left  = 0;

   // Receiver stall pattern
   int sink_mode    = 0;
   int sink_left    = 0;
   int sink_phase   = 0;

   tts_stream_if #(.payload_type(tts_req_type)) req_chan ();
   tts_stream_if #(.payload_type(tts_rsp_type)) rsp_chan ();

   tone_track_sequencer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tts_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_payload    (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_payload    (rsp_chan.payload),
      .pending_count  (pending),
      .mismatch_count (mismatches)
   );

   always #2 clock = ~clock;

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[tone_track_sequencer] ERROR");
         $finish;
      end
   end

   // Result sink: switch between randomly chosen stall modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            sink_left = $urandom_range(64, 256);
         end
         sink_left--;
         sink_phase++;
         case (sink_mode)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_chan.ready <= ($urandom_range(0, 9) < 3);
            default: rsp_chan.ready <= ((sink_phase % 7) < 4);
         endcase
      end
   end

   // Send one request beat; open a new burst after a random gap when one runs out
   task automatic send_beat(input logic kind, input logic [7:0] trk, input logic [7:0] reps);
      tts_req_type beat;
      int          gap;
      beat.req_type     = kind;
      beat.track_id     = trk;
      beat.repeat_count = reps;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: gap = 0;
            5:             gap = $urandom_range(20, 30);
            default:       gap = $urandom_range(1, 8);
         endcase
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= beat;
      do @(posedge clock); while (!req_chan.ready);
      burst_left--;
      beats_sent++;
   endtask

   task automatic send_tick();
      send_beat(REQ_TICK, 8'($urandom), 8'($urandom));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_tick();
   endtask

   // Hold the sender until every outstanding result has come back
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   // One play request followed by ticks, often enough to play it through
   task automatic play_sequence();
      logic [7:0] trk;
      logic [7:0] reps;
      int         plays;
      int         notes;
      int         full;
      int         ticks;
      trk  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: reps = 8'($urandom_range(1, 3));
         6, 7:             reps = 8'd0;
         default:          reps = 8'($urandom);
      endcase
      plays = (reps == 8'd0) ? 256 : int'(reps);
      notes = (trk == 8'd3 || trk == 8'd4) ? 6 : 2;
      full  = plays * notes + 1;
      if (full <= TICK_CAP && $urandom_range(0, 9) < 7) begin
         ticks = full + $urandom_range(0, 2);
      end else begin
         ticks = $urandom_range(1, (full < TICK_CAP) ? full : TICK_CAP);
      end
      send_beat(REQ_PLAY, trk, reps);
      send_ticks(ticks);
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle tick, single play, out-of-range tracks, restart,
      // request while playing, zero repeat count, the long track
      send_tick();
      send_beat(REQ_PLAY, 8'd0, 8'd1);
      send_ticks(4);
      send_beat(REQ_PLAY, 8'hff, 8'd2);
      send_ticks(5);
      send_beat(REQ_PLAY, 8'd3, 8'hff);
      send_ticks(2);
      send_beat(REQ_PLAY, 8'd4, 8'd0);
      send_tick();
      send_beat(REQ_PLAY, 8'd5, 8'h80);
      send_tick();
      send_beat(REQ_PLAY, 8'd2, 8'd1);
      send_ticks(3);
      hold_until_drained();

      // Random: mostly well-formed play sequences, some stray ticks and drains
      while (beats_sent < ITEM_TOTAL) begin
         case ($urandom_range(0, 19))
            0, 1:    send_ticks($urandom_range(1, 3));
            2:       hold_until_drained();
            default: play_sequence();
         endcase
      end

      // Drain and let the pipeline settle before the verdict
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("[tone_track_sequencer] OK");
      end else begin
         $display("[tone_track_sequencer] ERROR");
      end
      $finish;
   end

endmodule
